### hw/rtl/one_shot_timer_slot_table_assert.svh
// ---------------------------------------------------------------------------
// one-shot timer slot table assertion macros
// concurrent assertion helpers clocked on clk, disabled while arst_n is low
// ---------------------------------------------------------------------------
`ifndef ONE_SHOT_TIMER_SLOT_TABLE_ASSERT_SVH
`define ONE_SHOT_TIMER_SLOT_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF

// property holds on every clock edge outside reset
`define OSTS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error(msg);

// antecedent in one cycle implies consequent in the next
`define OSTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define OSTS_ASSERT(label, prop, msg)
`define OSTS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

### hw/rtl/osts_pkg.sv
// ---------------------------------------------------------------------------
// osts_pkg
// shared types and constants of the one-shot timer slot table
// ---------------------------------------------------------------------------
package osts_pkg;

	localparam int SLOT_COUNT_DEF = 16;
	localparam int RESULT_CAP     = 16;
	localparam int CNT_W          = $clog2(RESULT_CAP + 1);

	localparam int KIND_W   = 2;
	localparam int TAG_W    = 8;
	localparam int DELAY_W  = 16;
	localparam int STATUS_W = 2;
	localparam int SLOT_W   = 4;
	localparam int IN_DATA_W  = 24;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [KIND_W-1:0] {
		KIND_REGISTER = 2'd0,
		KIND_TICK     = 2'd1,
		KIND_DISPATCH = 2'd2
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK      = 2'd0,
		STATUS_FULL    = 2'd1,
		STATUS_NO_FIRE = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_FREE  = 2'd0,
		PH_READY = 2'd1,
		PH_COUNT = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic [1:0]         phase;
		logic [DELAY_W-1:0] elapsed;
		logic [DELAY_W-1:0] limit;
		logic [TAG_W-1:0]   tag;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	// controller to datapath
	typedef struct packed {
		logic start;
		logic scan_en;
		logic fin_push;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic scan_last;
		logic has_result;
		logic out_free;
	} sts_t;

endpackage

### hw/rtl/osts_ram.sv
// ---------------------------------------------------------------------------
// osts_ram
// generic single write port, single read port ram with registered read
// ---------------------------------------------------------------------------
module osts_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

### hw/rtl/osts_ctrl.sv
// ---------------------------------------------------------------------------
// osts_ctrl
// request sequencer: accept, slot scan, final result hand-off
// ---------------------------------------------------------------------------
module osts_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  osts_pkg::sts_t     sts,
	output osts_pkg::cmd_t     cmd
);

	osts_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= osts_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			osts_pkg::ST_IDLE: begin
				if (s_tvalid) begin
					state_d = osts_pkg::ST_SCAN;
				end
			end
			osts_pkg::ST_SCAN: begin
				if (sts.scan_last) begin
					state_d = osts_pkg::ST_FINISH;
				end
			end
			osts_pkg::ST_FINISH: begin
				if (!sts.has_result || sts.out_free) begin
					state_d = osts_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = osts_pkg::ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		s_tready     = 1'b0;
		cmd.start    = 1'b0;
		cmd.scan_en  = 1'b0;
		cmd.fin_push = 1'b0;
		case (state_q)
			osts_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				cmd.start = s_tvalid;
			end
			osts_pkg::ST_SCAN: begin
				cmd.scan_en = 1'b1;
			end
			osts_pkg::ST_FINISH: begin
				cmd.fin_push = sts.has_result && sts.out_free;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

endmodule

### hw/rtl/osts_dp.sv
// ---------------------------------------------------------------------------
// osts_dp
// slot ram, per-slot valid bits, scan pointer, pending fire and output register
// ---------------------------------------------------------------------------
`include "one_shot_timer_slot_table_assert.svh"

module osts_dp #(
	parameter int SLOT_COUNT = osts_pkg::SLOT_COUNT_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  osts_pkg::cmd_t                    cmd,
	output osts_pkg::sts_t                    sts,
	input  logic [osts_pkg::KIND_W-1:0]       in_kind,
	input  logic [osts_pkg::TAG_W-1:0]        in_tag,
	input  logic [osts_pkg::DELAY_W-1:0]      in_delay,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [osts_pkg::OUT_DATA_W-1:0]   m_tdata,
	output logic                              m_tlast
);

	localparam int IW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(SLOT_COUNT - 1);

	logic [osts_pkg::KIND_W-1:0]   kind_q;
	logic [osts_pkg::TAG_W-1:0]    tag_q;
	logic [osts_pkg::DELAY_W-1:0]  delay_q;
	logic [IW-1:0]                 idx_q;
	logic                          found_q;
	logic [osts_pkg::SLOT_W-1:0]   found_slot_q;
	logic                          pend_vld_q;
	logic [osts_pkg::SLOT_W-1:0]   pend_slot_q;
	logic [osts_pkg::TAG_W-1:0]    pend_tag_q;
	logic [osts_pkg::CNT_W-1:0]    n_q;
	logic [SLOT_COUNT-1:0]         valid_q;

	logic                          m_tvalid_q;
	logic [osts_pkg::STATUS_W-1:0] status_q;
	logic [osts_pkg::SLOT_W-1:0]   slot_q;
	logic [osts_pkg::TAG_W-1:0]    ftag_q;
	logic                          fire_q;
	logic                          last_q;

	osts_pkg::entry_t              rd_entry;
	osts_pkg::entry_t              wr_entry;
	logic [osts_pkg::ENTRY_W-1:0]  rd_raw;
	logic [IW-1:0]                 rd_addr;
	logic                          ram_we;
	logic [1:0]                    phase_eff;
	logic [IW+osts_pkg::SLOT_W-1:0] idx_wide;
	logic [osts_pkg::SLOT_W-1:0]   idx_slot;

	logic reg_hit, tick_hit, fire_hit, stall, advance, out_free, push_mid;

	logic [osts_pkg::STATUS_W-1:0] fin_status;
	logic [osts_pkg::SLOT_W-1:0]   fin_slot;
	logic [osts_pkg::TAG_W-1:0]    fin_tag;
	logic                          fin_fire;

	assign rd_entry  = osts_pkg::entry_t'(rd_raw);
	assign phase_eff = valid_q[idx_q] ? rd_entry.phase : osts_pkg::PH_FREE;
	assign idx_wide  = {{osts_pkg::SLOT_W{1'b0}}, idx_q};
	assign idx_slot  = idx_wide[osts_pkg::SLOT_W-1:0];

	assign out_free = !m_tvalid_q || m_tready;

	assign reg_hit  = (kind_q == osts_pkg::KIND_REGISTER) && !found_q &&
		(phase_eff == osts_pkg::PH_FREE);
	assign tick_hit = (kind_q == osts_pkg::KIND_TICK) && (phase_eff == osts_pkg::PH_COUNT);
	assign fire_hit = (kind_q == osts_pkg::KIND_DISPATCH) &&
		(phase_eff == osts_pkg::PH_READY) && (rd_entry.tag != '0) &&
		(n_q < osts_pkg::CNT_W'(osts_pkg::RESULT_CAP));

	// a second fire needs the output register for the held one
	assign stall    = cmd.scan_en && fire_hit && pend_vld_q && !out_free;
	assign advance  = cmd.scan_en && !stall;
	assign ram_we   = advance && (reg_hit || tick_hit || fire_hit);
	assign push_mid = advance && fire_hit && pend_vld_q;

	// on a stall the current slot is read again so its data stays in place
	always_comb begin
		if (advance && (idx_q != LAST_IDX)) begin
			rd_addr = idx_q + IW'(1);
		end else if (cmd.scan_en) begin
			rd_addr = idx_q;
		end else begin
			rd_addr = '0;
		end
	end

	always_comb begin
		wr_entry = rd_entry;
		if (reg_hit) begin
			wr_entry.phase   = osts_pkg::PH_COUNT;
			wr_entry.elapsed = '0;
			wr_entry.limit   = delay_q;
			wr_entry.tag     = tag_q;
		end else if (tick_hit) begin
			if (rd_entry.elapsed < rd_entry.limit) begin
				wr_entry.elapsed = rd_entry.elapsed + osts_pkg::DELAY_W'(1);
			end else begin
				wr_entry.elapsed = '0;
				wr_entry.phase   = osts_pkg::PH_READY;
			end
		end else if (fire_hit) begin
			wr_entry.phase = osts_pkg::PH_FREE;
			wr_entry.tag   = '0;
		end
	end

	osts_ram #(
		.WIDTH (osts_pkg::ENTRY_W),
		.DEPTH (SLOT_COUNT)
	) u_ram (
		.clk     (clk),
		.we      (ram_we),
		.wr_addr (idx_q),
		.wr_data (wr_entry),
		.rd_addr (rd_addr),
		.rd_data (rd_raw)
	);

	// final result of a register or dispatch request
	always_comb begin
		fin_status = osts_pkg::STATUS_OK;
		fin_slot   = '0;
		fin_tag    = '0;
		fin_fire   = 1'b0;
		case (kind_q)
			osts_pkg::KIND_REGISTER: begin
				if (found_q) begin
					fin_slot = found_slot_q;
				end else begin
					fin_status = osts_pkg::STATUS_FULL;
				end
			end
			osts_pkg::KIND_DISPATCH: begin
				if (pend_vld_q) begin
					fin_slot = pend_slot_q;
					fin_tag  = pend_tag_q;
					fin_fire = 1'b1;
				end else begin
					fin_status = osts_pkg::STATUS_NO_FIRE;
				end
			end
			default: begin
				fin_status = osts_pkg::STATUS_OK;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			kind_q  <= in_kind;
			tag_q   <= in_tag;
			delay_q <= in_delay;
		end
		if (advance && reg_hit) begin
			found_slot_q <= idx_slot;
		end
		if (advance && fire_hit) begin
			pend_slot_q <= idx_slot;
			pend_tag_q  <= rd_entry.tag;
		end
		if (push_mid) begin
			status_q <= osts_pkg::STATUS_OK;
			slot_q   <= pend_slot_q;
			ftag_q   <= pend_tag_q;
			fire_q   <= 1'b1;
			last_q   <= 1'b0;
		end else if (cmd.fin_push) begin
			status_q <= fin_status;
			slot_q   <= fin_slot;
			ftag_q   <= fin_tag;
			fire_q   <= fin_fire;
			last_q   <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q      <= '0;
			found_q    <= 1'b0;
			pend_vld_q <= 1'b0;
			n_q        <= '0;
			valid_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				idx_q      <= '0;
				found_q    <= 1'b0;
				pend_vld_q <= 1'b0;
				n_q        <= '0;
			end else if (advance) begin
				idx_q <= idx_q + IW'(1);
				if (reg_hit) begin
					found_q        <= 1'b1;
					valid_q[idx_q] <= 1'b1;
				end
				if (fire_hit) begin
					pend_vld_q <= 1'b1;
					n_q        <= n_q + osts_pkg::CNT_W'(1);
				end
			end
			if (push_mid || cmd.fin_push) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign sts.scan_last  = advance && (idx_q == LAST_IDX);
	assign sts.has_result = (kind_q == osts_pkg::KIND_REGISTER) ||
		(kind_q == osts_pkg::KIND_DISPATCH);
	assign sts.out_free   = out_free;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {1'b0, fire_q, ftag_q, slot_q, status_q};
	assign m_tlast  = last_q;

	`OSTS_ASSERT(a_stall_only_dispatch, stall |-> (kind_q == osts_pkg::KIND_DISPATCH && pend_vld_q), "scan stalled outside a dispatch with a held fire")
	`OSTS_ASSERT(a_fire_cap, n_q <= osts_pkg::CNT_W'(osts_pkg::RESULT_CAP), "fire count past the cap")
	`OSTS_ASSERT(a_write_in_scan, ram_we |-> cmd.scan_en, "slot ram written outside a scan")
	`OSTS_ASSERT_NEXT(a_mid_not_last, push_mid, m_tvalid_q && !last_q, "mid-scan fire not presented as a non-final result")

endmodule

### hw/rtl/one_shot_timer_slot_table.sv
// ---------------------------------------------------------------------------
// one_shot_timer_slot_table
// table of one-shot timer slots with register, tick and dispatch requests
// ---------------------------------------------------------------------------
// The block keeps SLOT_COUNT one-shot timer slots, each free, counting or
// ready. A register request (tuser 0) takes the lowest free slot, stores the
// tag and delay and answers with the slot, or with table full. A tick request
// (tuser 1) advances every counting slot; a slot with delay d turns ready on
// the (d+1)-th tick; a tick gives no result. A dispatch request (tuser 2)
// emits every ready slot with a nonzero tag in slot order, at most 16, frees
// them, and marks the final one with tlast; with nothing to fire it answers
// status 2. Slots that turn ready with tag 0 are never freed. tuser 3 is
// ignored. Every request walks the slot ram one slot per cycle through its
// single read port, except while a dispatch finds the output register still
// held by the sink with a second fire waiting. The next request is accepted
// only after the scan and, for a register or dispatch request, after its
// final result has gone into the output register. No clearing pass is
// needed after reset: per-slot valid bits mark the free slots.
// ---------------------------------------------------------------------------
module one_shot_timer_slot_table #(
	parameter int SLOT_COUNT = osts_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// request channel
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [osts_pkg::IN_DATA_W-1:0]  s_tdata,   // task_tag[7:0], delay[23:8]
	input  logic [osts_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
	// result channel
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [osts_pkg::OUT_DATA_W-1:0] m_tdata,   // status[1:0], slot[5:2],
	                                                   // fired_tag[13:6], fire[14], zero[15]
	output logic                            m_tlast    // last
);

	osts_pkg::cmd_t cmd;
	osts_pkg::sts_t sts;

	// sequencer: idle, scan over all slots, hand-off of the final result
	osts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// slot storage and result path
	osts_dp #(
		.SLOT_COUNT (SLOT_COUNT)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_kind  (s_tuser),
		.in_tag   (s_tdata[osts_pkg::TAG_W-1:0]),
		.in_delay (s_tdata[osts_pkg::TAG_W +: osts_pkg::DELAY_W]),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

### sim/osts_checker.sv
// ---------------------------------------------------------------------------
// osts_checker
// watches the request and result channels of the timer slot table, predicts
// the results of every accepted request and compares them in order
// ---------------------------------------------------------------------------
module osts_checker #(
	parameter int SLOT_COUNT = osts_pkg::SLOT_COUNT_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [osts_pkg::IN_DATA_W-1:0]  s_tdata,   // task_tag[7:0], delay[23:8]
	input  logic [osts_pkg::KIND_W-1:0]     s_tuser,   // kind[1:0]
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	input  logic [osts_pkg::OUT_DATA_W-1:0] m_tdata,   // status[1:0], slot[5:2],
	                                                   // fired_tag[13:6], fire[14], zero[15]
	input  logic                            m_tlast,   // last
	output int                              fail_count,
	output int                              pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import osts_pkg::*;

	typedef struct packed {
		status_t            status;
		logic [SLOT_W-1:0]  slot;
		logic [TAG_W-1:0]   tag;
		logic               fire;
		logic               last;
	} timer_result_t;

	// shadow copy of the slot table
	phase_t             shadow_phase   [SLOT_COUNT];
	logic [DELAY_W-1:0] shadow_elapsed [SLOT_COUNT];
	logic [DELAY_W-1:0] shadow_limit   [SLOT_COUNT];
	logic [TAG_W-1:0]   shadow_tag     [SLOT_COUNT];

	timer_result_t awaited_results[$];

	assign pending = awaited_results.size();

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("%0t ns: mismatch in %s: got %0d, expected %0d", $time, what, got, want);
		fail_count++;
	endtask

	task automatic push_result(input status_t st, input logic [SLOT_W-1:0] sl,
		input logic [TAG_W-1:0] tg, input logic fr, input logic lst);
		timer_result_t r;
		r.status = st;
		r.slot   = sl;
		r.tag    = tg;
		r.fire   = fr;
		r.last   = lst;
		awaited_results.push_back(r);
	endtask

	// advance the shadow table by one request and queue what it should emit
	task automatic apply_timer_request(input logic [KIND_W-1:0] kind,
		input logic [TAG_W-1:0] tag, input logic [DELAY_W-1:0] dly);
		int free_slot;
		int fire_total;
		int fired;
		free_slot  = -1;
		fire_total = 0;
		fired      = 0;
		case (kind)
			KIND_REGISTER: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (free_slot < 0 && shadow_phase[i] == PH_FREE)
						free_slot = i;
				end
				if (free_slot >= 0) begin
					shadow_tag[free_slot]     = tag;
					shadow_limit[free_slot]   = dly;
					shadow_elapsed[free_slot] = '0;
					shadow_phase[free_slot]   = PH_COUNT;
					push_result(STATUS_OK, SLOT_W'(free_slot), '0, 1'b0, 1'b1);
				end else begin
					push_result(STATUS_FULL, '0, '0, 1'b0, 1'b1);
				end
			end
			KIND_TICK: begin
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (shadow_phase[i] == PH_COUNT) begin
						if (shadow_elapsed[i] < shadow_limit[i]) begin
							shadow_elapsed[i] = shadow_elapsed[i] + 1'b1;
						end else begin
							shadow_elapsed[i] = '0;
							shadow_phase[i]   = PH_READY;
						end
					end
				end
			end
			KIND_DISPATCH: begin
				// count first so the final fire can carry last
				for (int i = 0; i < SLOT_COUNT; i++) begin
					if (shadow_phase[i] == PH_READY && shadow_tag[i] != '0)
						fire_total++;
				end
				if (fire_total > RESULT_CAP)
					fire_total = RESULT_CAP;
				for (int i = 0; i < SLOT_COUNT && fired < fire_total; i++) begin
					if (shadow_phase[i] == PH_READY && shadow_tag[i] != '0) begin
						push_result(STATUS_OK, SLOT_W'(i), shadow_tag[i], 1'b1,
							fired == fire_total - 1);
						fired++;
						shadow_tag[i]   = '0;
						shadow_phase[i] = PH_FREE;
					end
				end
				if (fire_total == 0)
					push_result(STATUS_NO_FIRE, '0, '0, 1'b0, 1'b1);
			end
			default: begin
				// unknown kind is dropped
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		timer_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < SLOT_COUNT; i++) begin
				shadow_phase[i]   = PH_FREE;
				shadow_elapsed[i] = '0;
				shadow_limit[i]   = '0;
				shadow_tag[i]     = '0;
			end
			awaited_results.delete();
			fail_count = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (awaited_results.size() == 0) begin
					report_mismatch("unexpected result, tdata", m_tdata, 0);
				end else begin
					want = awaited_results.pop_front();
					if (m_tdata[1:0] != want.status)
						report_mismatch("status", m_tdata[1:0], want.status);
					if (m_tdata[5:2] != want.slot)
						report_mismatch("slot", m_tdata[5:2], want.slot);
					if (m_tdata[13:6] != want.tag)
						report_mismatch("fired_tag", m_tdata[13:6], want.tag);
					if (m_tdata[14] != want.fire)
						report_mismatch("fire", m_tdata[14], want.fire);
					if (m_tlast != want.last)
						report_mismatch("last", m_tlast, want.last);
				end
			end
			if (s_tvalid && s_tready)
				apply_timer_request(s_tuser, s_tdata[TAG_W-1:0],
					s_tdata[TAG_W +: DELAY_W]);
		end
	end

endmodule

### sim/tb.sv
// ---------------------------------------------------------------------------
// tb
// stimulus and verdict for the one-shot timer slot table: directed requests
// for the corner cases, then random register, tick, dispatch and unused-kind
// traffic in three idling patterns, the checker comparing every result
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import osts_pkg::*;

	localparam int SLOT_COUNT = SLOT_COUNT_DEF;
	localparam int RANDOM_REQUESTS = 350;
	// tuser code that the block must drop
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;    // task_tag[7:0], delay[23:8]
	logic [KIND_W-1:0]     s_tuser = '0;    // kind[1:0]
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // status[1:0], slot[5:2], fired_tag[13:6],
	                                        // fire[14], zero[15]
	logic                  m_tlast;         // last

	int fail_count;
	int pending;

	// idle chances in percent, changed as the run moves through its phases
	int tx_idle_pct = 31;
	int rx_idle_pct = 49;

	one_shot_timer_slot_table #(
		.SLOT_COUNT(SLOT_COUNT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast)
	);

	osts_checker #(
		.SLOT_COUNT(SLOT_COUNT)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tlast(m_tlast),
		.fail_count(fail_count),
		.pending(pending)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// result sink, stalls at random per cycle
	initial begin
		forever begin
			@(posedge clk);
			m_tready <= ($urandom_range(99) >= rx_idle_pct);
		end
	end

	// hard stop well past the slowest correct run
	initial begin
		#5_000_000;
		$display("tb failed");
		$finish;
	end

	// offer one request, with random idle cycles ahead of it, and hold it until taken;
	// tvalid stays high between back-to-back requests
	task automatic send_request(input logic [KIND_W-1:0] kind, input logic [TAG_W-1:0] tag,
		input logic [DELAY_W-1:0] dly);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {dly, tag};
		do @(posedge clk); while (!s_tready);
	endtask

	initial begin
		int sel;
		logic [TAG_W-1:0]   rnd_tag;
		logic [DELAY_W-1:0] rnd_delay;
		int counted;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// fill the whole table with zero delays, one over the top gives table full
		for (int i = 0; i < SLOT_COUNT; i++)
			send_request(KIND_REGISTER, (i == SLOT_COUNT - 1) ? 8'hFF : TAG_W'(i * 13 + 1), '0);
		send_request(KIND_REGISTER, 8'hAA, 16'h5555);
		// a single tick makes every slot ready, one dispatch fires the maximum
		send_request(KIND_TICK, '0, '0);
		send_request(KIND_DISPATCH, '0, '0);
		// nothing left to fire
		send_request(KIND_DISPATCH, '1, '1);
		// tag zero slot turns ready but is never freed, so dispatch reports nothing
		send_request(KIND_REGISTER, '0, '0);
		// longest delay, this slot stays counting for the rest of the run
		send_request(KIND_REGISTER, 8'hFF, 16'hFFFF);
		send_request(KIND_TICK, '1, '1);
		send_request(KIND_DISPATCH, '0, '0);
		// unknown kind is dropped without a result
		send_request(KIND_UNUSED, 8'h5A, 16'hA5A5);

		counted = 0;
		while (counted < RANDOM_REQUESTS) begin
			if (counted == RANDOM_REQUESTS / 3) begin
				tx_idle_pct = 49;
				rx_idle_pct = 31;
			end else if (counted == 2 * RANDOM_REQUESTS / 3) begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			sel = $urandom_range(99);
			if (sel < 35) begin
				// tag zero only now and then, each one pins a slot for good
				rnd_tag = ($urandom_range(99) == 0) ? '0 : TAG_W'($urandom_range(1, 255));
				if ($urandom_range(15) < 12)
					rnd_delay = DELAY_W'($urandom_range(0, 6));
				else
					rnd_delay = DELAY_W'($urandom_range(7, 40));
				send_request(KIND_REGISTER, rnd_tag, rnd_delay);
				counted++;
			end else if (sel < 75) begin
				send_request(KIND_TICK, TAG_W'($urandom), DELAY_W'($urandom));
				counted++;
			end else if (sel < 95) begin
				send_request(KIND_DISPATCH, TAG_W'($urandom), DELAY_W'($urandom));
				counted++;
			end else begin
				send_request(KIND_UNUSED, TAG_W'($urandom), DELAY_W'($urandom));
			end
		end
		s_tvalid <= 1'b0;

		// drain, then let any last scan run out
		while (pending != 0) @(posedge clk);
		repeat (2 * SLOT_COUNT + 8) @(posedge clk);

		// every predicted result must have been seen
		if (fail_count == 0 && pending == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/osts_pkg.sv
hw/rtl/osts_ram.sv
hw/rtl/osts_ctrl.sv
hw/rtl/osts_dp.sv
hw/rtl/one_shot_timer_slot_table.sv
sim/osts_checker.sv
sim/tb.sv
